// ===== design/mm64_pkg.sv =====
package mm64_pkg;

   localparam logic [63:0] MIX_MUL    = 64'hC6A4A7935BD1E995;
   localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
   localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
   localparam int unsigned MIX_SHIFT  = 47;
   localparam logic [31:0] SEED_RESET = 32'hE17A1465;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;
   localparam logic [3:0]  WORD_BYTES = 4'd8;

   localparam int unsigned FIFO_DEPTH = 2;

   // how the back end folds one word into the hash
   typedef enum logic [1:0] {
      MIX_FULL,
      MIX_TAIL,
      MIX_NONE
   } mix_kind_type;

   typedef struct packed {
      logic [63:0]  word;
      mix_kind_type kind;
      logic         first;
      logic         last;
      logic [31:0]  total_length;
      logic         mismatch;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic        busy;
      logic [63:0] result;
   } mul_rsp_type;

endpackage

// ===== design/mm64_if.sv =====
interface mm64_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  bytes_valid;
   logic        first;
   logic        last;
   logic [31:0] total_length;

   modport source (output valid, data_word, bytes_valid, first, last, total_length,
                   input ready);
   modport sink   (input valid, data_word, bytes_valid, first, last, total_length,
                   output ready);
endinterface

interface mm64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   logic        length_mismatch;

   modport source (output valid, hash_value, length_mismatch, input ready);
   modport sink   (input valid, hash_value, length_mismatch, output ready);
endinterface

interface mm64_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] seed;

   modport source (output valid, seed, input ready);
   modport sink   (input valid, seed, output ready);
endinterface

// ===== design/murmur64a_hash_top.sv =====
// channel  | port    | dir | payload
// ---------+---------+-----+------------------------------------------------------
// request  | req_ch  | in  | data_word, bytes_valid, first, last, total_length
// response | rsp_ch  | out | hash_value, length_mismatch (one beat per last)
// config   | csr_ch  | in  | seed (always ready outside reset)
//
// One 32x32 multiplier does all the work; a 64-bit multiply runs through steps S1 to S4.
// Full word: three multiplies, one more when first is set, one for finalization on last.
// Last word: tail adds one multiply to finalization, empty adds none; init not included.
// Synchronous reset clears control, the hash accumulator and the byte counters.
// A small queue lets requests be taken while the back end works; a response
// beat waiting on rsp_ch stalls only the final step of the next message.
module murmur64a_hash_top
   import mm64_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   mm64_req_if.sink   req_ch,
   mm64_rsp_if.source rsp_ch,
   mm64_csr_if.sink   csr_ch
);

   logic [31:0] seed_ff;
   logic        push, fifo_full, fifo_pop, fifo_valid;
   entry_type   push_entry, pop_entry;

   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         seed_ff <= csr_ch.seed;
      end
   end

   mm64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mm64_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (fifo_pop),
      .pop_valid  (fifo_valid),
      .pop_entry  (pop_entry)
   );

   mm64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .fifo_valid (fifo_valid),
      .fifo_entry (pop_entry),
      .fifo_pop   (fifo_pop),
      .rsp        (rsp_ch)
   );

endmodule

// ===== design/mm64_front.sv =====
module mm64_front
   import mm64_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   mm64_req_if.sink      req,
   input  logic          fifo_full,
   output logic          push,
   output entry_type     push_entry
);

   logic [31:0] bytes_seen_ff, bytes_seen_in;
   logic [31:0] declared_len_ff, declared_len_in;
   logic [3:0]  nbytes;
   logic [63:0] masked_word;
   logic [31:0] seen_base;

   assign req.ready = !fifo_full && !reset;
   assign push      = req.valid && req.ready;

   assign nbytes = (req.bytes_valid > WORD_BYTES) ? WORD_BYTES : req.bytes_valid;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked_word[i*8 +: 8] = (4'(i) < nbytes) ? (req.data_word[i*8 +: 8] & BYTE_MASK)
                                                  : 8'h00;
      end
   end

   assign seen_base       = req.first ? 32'd0 : bytes_seen_ff;
   assign bytes_seen_in   = seen_base + {28'd0, nbytes};
   assign declared_len_in = req.first ? req.total_length : declared_len_ff;

   always_comb begin
      push_entry.word         = masked_word;
      push_entry.first        = req.first;
      push_entry.last         = req.last;
      push_entry.total_length = req.total_length;
      push_entry.mismatch     = (bytes_seen_in != declared_len_in);
      if (!req.last || nbytes == WORD_BYTES) begin
         push_entry.kind = MIX_FULL;
      end else if (nbytes == 4'd0) begin
         push_entry.kind = MIX_NONE;
      end else begin
         push_entry.kind = MIX_TAIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff   <= '0;
         declared_len_ff <= '0;
      end else if (push) begin
         bytes_seen_ff   <= bytes_seen_in;
         declared_len_ff <= declared_len_in;
      end
   end

endmodule

// ===== design/mm64_fifo.sv =====
module mm64_fifo
   import mm64_pkg::*;
#(
   parameter int unsigned DEPTH = FIFO_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/mm64_mul.sv =====
module mm64_mul
   import mm64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   // low 64 bits of operand * MIX_MUL from three 32x32 products on one multiplier
   typedef enum logic [2:0] {
      M_IDLE,
      M_S1,
      M_S2,
      M_S3,
      M_S4
   } step_type;

   step_type    step_ff;
   logic [63:0] a_ff;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [31:0] op_a, op_b;
   logic [63:0] product;

   assign op_a    = (step_ff == M_S3) ? a_ff[63:32] : a_ff[31:0];
   assign op_b    = (step_ff == M_S2) ? MIX_MUL_HI : MIX_MUL_LO;
   assign product = {32'd0, op_a} * {32'd0, op_b};

   assign mul_rsp.busy   = (step_ff != M_IDLE);
   assign mul_rsp.result = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= M_IDLE;
      end else begin
         case (step_ff)
            M_IDLE: begin
               if (mul_req.start) begin
                  a_ff    <= mul_req.operand;
                  step_ff <= M_S1;
               end
            end
            M_S1: begin
               prod_ff <= product;
               step_ff <= M_S2;
            end
            M_S2: begin
               acc_ff  <= prod_ff;
               prod_ff <= {product[31:0], 32'd0};
               step_ff <= M_S3;
            end
            M_S3: begin
               acc_ff  <= acc_ff + prod_ff;
               prod_ff <= {product[31:0], 32'd0};
               step_ff <= M_S4;
            end
            M_S4: begin
               acc_ff  <= acc_ff + prod_ff;
               step_ff <= M_IDLE;
            end
            default: begin
               step_ff <= M_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/mm64_back.sv =====
module mm64_back
   import mm64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] seed,
   input  logic        fifo_valid,
   input  entry_type   fifo_entry,
   output logic        fifo_pop,
   mm64_rsp_if.source  rsp
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_INIT,
      B_DISPATCH,
      B_K1,
      B_K2,
      B_HMUL,
      B_FIN0,
      B_FIN1
   } state_type;

   state_type   state_ff;
   entry_type   ent_ff;
   logic [63:0] hash_acc_ff;
   logic        rsp_valid_ff;
   logic [63:0] hash_out_ff;
   logic        mismatch_out_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   logic [63:0] mix_res;
   logic [63:0] final_hash;
   logic        out_load;

   mm64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign mix_res    = mul_rsp.result;
   assign final_hash = mix_res ^ (mix_res >> MIX_SHIFT);
   assign fifo_pop   = (state_ff == B_IDLE) && fifo_valid;
   assign out_load   = (state_ff == B_FIN1) && !mul_rsp.busy && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hash_value      = hash_out_ff;
   assign rsp.length_mismatch = mismatch_out_ff;

   always_comb begin
      mul_req = '0;
      case (state_ff)
         B_IDLE: begin
            if (fifo_valid && fifo_entry.first) begin
               mul_req.start   = 1'b1;
               mul_req.operand = {32'd0, fifo_entry.total_length};
            end
         end
         B_DISPATCH: begin
            if (ent_ff.kind == MIX_FULL) begin
               mul_req.start   = 1'b1;
               mul_req.operand = ent_ff.word;
            end else if (ent_ff.kind == MIX_TAIL) begin
               mul_req.start   = 1'b1;
               mul_req.operand = hash_acc_ff ^ ent_ff.word;
            end
         end
         B_K1: begin
            // k ^= k >> 47, then second multiply
            mul_req.start   = !mul_rsp.busy;
            mul_req.operand = mix_res ^ (mix_res >> MIX_SHIFT);
         end
         B_K2: begin
            mul_req.start   = !mul_rsp.busy;
            mul_req.operand = hash_acc_ff ^ mix_res;
         end
         B_FIN0: begin
            mul_req.start   = 1'b1;
            mul_req.operand = hash_acc_ff ^ (hash_acc_ff >> MIX_SHIFT);
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         hash_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff    <= 1'b1;
            hash_out_ff     <= final_hash;
            mismatch_out_ff <= ent_ff.mismatch;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            B_IDLE: begin
               if (fifo_valid) begin
                  ent_ff   <= fifo_entry;
                  state_ff <= fifo_entry.first ? B_INIT : B_DISPATCH;
               end
            end
            B_INIT: begin
               if (!mul_rsp.busy) begin
                  hash_acc_ff <= {32'd0, seed} ^ mix_res;
                  state_ff    <= B_DISPATCH;
               end
            end
            B_DISPATCH: begin
               case (ent_ff.kind)
                  MIX_FULL: state_ff <= B_K1;
                  MIX_TAIL: state_ff <= B_HMUL;
                  MIX_NONE: state_ff <= B_FIN0;
                  default:  state_ff <= B_IDLE;
               endcase
            end
            B_K1: begin
               if (!mul_rsp.busy) begin
                  state_ff <= B_K2;
               end
            end
            B_K2: begin
               if (!mul_rsp.busy) begin
                  state_ff <= B_HMUL;
               end
            end
            B_HMUL: begin
               if (!mul_rsp.busy) begin
                  hash_acc_ff <= mix_res;
                  state_ff    <= ent_ff.last ? B_FIN0 : B_IDLE;
               end
            end
            B_FIN0: begin
               state_ff <= B_FIN1;
            end
            B_FIN1: begin
               if (out_load) begin
                  hash_acc_ff <= final_hash;
                  state_ff    <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/mm64_checker.sv =====
module mm64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] hash_value,
   input logic        length_mismatch,
   input logic        csr_ready
);

   // response beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hash_value) && $stable(length_mismatch))
      else $error("response beat dropped or changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no request beat is taken while in reset
   a_req_blocked_in_reset: assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("request port ready during reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready outside reset");

endmodule

bind murmur64a_hash_top mm64_checker u_mm64_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .hash_value      (rsp_ch.hash_value),
   .length_mismatch (rsp_ch.length_mismatch),
   .csr_ready       (csr_ch.ready)
);

// ===== dv/tb_murmur64a_hash_top.sv =====
`timescale 1ns / 100ps

module tb_murmur64a_hash_top;
   import mm64_pkg::*;

   localparam int unsigned ITEM_GOAL    = 1850;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned SETTLE_WAIT  = 200;
   localparam int unsigned STALL_LIMIT  = 20000;

   typedef struct {
      logic [63:0] hash;
      logic        mismatch;
   } digest_type;

   // Tracks the running hash state and the digests still owed by the block.
   class hash_scoreboard;
      logic [63:0] seed;
      logic [63:0] acc;
      logic [31:0] byte_count;
      logic [31:0] declared;
      digest_type  owed[$];
      int unsigned errors;

      function new();
         seed       = {32'd0, SEED_RESET};
         acc        = '0;
         byte_count = '0;
         declared   = '0;
         errors     = 0;
      endfunction

      function void set_seed(logic [31:0] value);
         seed = {32'd0, value};
      endfunction

      function logic [63:0] fold_word(logic [63:0] h, logic [63:0] k);
         k = k * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = h ^ k;
         return h * MIX_MUL;
      endfunction

      function void note_word(logic [63:0] word, logic [3:0] nbytes_in, logic first,
                              logic last, logic [31:0] tlen);
         int unsigned n;
         logic [63:0] w;
         logic [63:0] h;
         digest_type  d;
         n = (nbytes_in > WORD_BYTES) ? 8 : int'(nbytes_in);
         w = word;
         if (n < 8) begin
            w = word & ((64'd1 << (8 * n)) - 64'd1);
         end
         if (first) begin
            acc        = seed ^ ({32'd0, tlen} * MIX_MUL);
            byte_count = '0;
            declared   = tlen;
         end
         byte_count = byte_count + 32'(n);
         h = acc;
         if (!last) begin
            acc = fold_word(h, w);
            return;
         end
         if (n == 8) begin
            h = fold_word(h, w);
         end else if (n != 0) begin
            h = (h ^ w) * MIX_MUL;
         end
         h = h ^ (h >> MIX_SHIFT);
         h = h * MIX_MUL;
         h = h ^ (h >> MIX_SHIFT);
         acc = h;
         d.hash     = h;
         d.mismatch = (byte_count != declared);
         owed.push_back(d);
      endfunction

      function void check_digest(logic [63:0] hash, logic mismatch);
         digest_type d;
         if (owed.size() == 0) begin
            $error("hash beat with no message outstanding: hash_value %h", hash);
            errors++;
            return;
         end
         d = owed.pop_front();
         if (hash !== d.hash) begin
            $error("hash_value: expected %h, got %h", d.hash, hash);
            errors++;
         end
         if (mismatch !== d.mismatch) begin
            $error("length_mismatch: expected %0b, got %0b", d.mismatch, mismatch);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   mm64_req_if req_if ();
   mm64_rsp_if rsp_if ();
   mm64_csr_if csr_if ();

   murmur64a_hash_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   hash_scoreboard sb;
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;
   int unsigned    words_sent;
   int unsigned    quiet_cycles;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // receiver: ready toggles at the falling edge
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_digest(rsp_if.hash_value, rsp_if.length_mismatch);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_murmur64a_hash_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] any_word();
      return {$urandom, $urandom};
   endfunction

   // called and returns at a falling edge
   task automatic send_beat(logic [63:0] word, logic [3:0] nbytes, logic first, logic last,
                            logic [31:0] tlen);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_word    <= word;
      req_if.bytes_valid  <= nbytes;
      req_if.first        <= first;
      req_if.last         <= last;
      req_if.total_length <= tlen;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_word(word, nbytes, first, last, tlen);
      words_sent++;
      @(negedge clock);
   endtask

   // len bytes in little-endian words; a length that fills its last word either
   // ends on a full word or on an extra empty word
   task automatic send_message(int unsigned len, bit empty_tail, logic [31:0] tlen,
                               bit with_first);
      int full_words;
      int unsigned rem;
      logic [3:0] tail_bytes;
      rem = len % 8;
      if (len == 0) empty_tail = 1'b1;
      full_words = (rem == 0 && !empty_tail) ? int'(len / 8) - 1 : int'(len / 8);
      tail_bytes = (rem != 0) ? 4'(rem) : (empty_tail ? 4'd0 : WORD_BYTES);
      for (int i = 0; i < full_words; i++) begin
         send_beat(any_word(), WORD_BYTES, with_first && (i == 0), 1'b0, tlen);
      end
      send_beat(any_word(), tail_bytes, with_first && (full_words == 0), 1'b1, tlen);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      csr_if.valid <= 1'b1;
      csr_if.seed  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.set_seed(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_directed();
      // words before any first continue from the reset state
      send_beat(any_word(), 4'd8, 1'b0, 1'b0, 32'd0);
      send_beat(any_word(), 4'd3, 1'b0, 1'b1, 32'd0);
      // empty message, garbage data must be ignored
      send_beat('1, 4'd0, 1'b1, 1'b1, 32'd0);
      send_beat('1, 4'd5, 1'b1, 1'b1, 32'd5);
      send_beat('1, 4'd7, 1'b1, 1'b1, 32'd7);
      send_beat('1, 4'd8, 1'b1, 1'b1, 32'd8);
      // byte count above eight saturates
      send_beat(any_word(), 4'd15, 1'b1, 1'b1, 32'd8);
      send_beat('0, 4'd8, 1'b1, 1'b0, 32'd16);
      send_beat('0, 4'd8, 1'b0, 1'b1, 32'd16);
      // full words closed by an empty last word
      send_beat(any_word(), 4'd8, 1'b1, 1'b0, 32'd16);
      send_beat(any_word(), 4'd8, 1'b0, 1'b0, 32'd16);
      send_beat(any_word(), 4'd0, 1'b0, 1'b1, 32'd16);
      // short word in the middle gets mixed as a full one
      send_beat(any_word(), 4'd3, 1'b1, 1'b0, 32'd11);
      send_beat(any_word(), 4'd8, 1'b0, 1'b1, 32'd11);
      // continues from the finalized hash
      send_beat(any_word(), 4'd4, 1'b0, 1'b1, 32'd0);
      send_beat(any_word(), 4'd2, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_beat(any_word(), 4'd9, 1'b1, 1'b0, 32'd20);
      send_beat(any_word(), 4'd4, 1'b0, 1'b1, 32'd20);
   endtask

   task automatic run_random(int unsigned goal, int unsigned idle_pct, int unsigned stall_pct);
      int unsigned pick;
      int unsigned len;
      int unsigned burst_left;
      bit          empty_tail;
      burst_left = 0;
      while (words_sent < goal) begin
         if (burst_left == 0 && $urandom_range(99) < 5) begin
            burst_left = $urandom_range(15, 5);
         end
         if (burst_left != 0) begin
            burst_left--;
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else begin
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
         end
         pick       = $urandom_range(99);
         len        = ($urandom_range(9) == 0) ? $urandom_range(160, 41) : $urandom_range(40);
         empty_tail = $urandom_range(1);
         if (pick < 85) begin
            send_message(len, empty_tail, 32'(len), 1'b1);
         end else if (pick < 90) begin
            send_message(len, empty_tail, $urandom, 1'b1);
         end else if (pick < 94) begin
            send_message(len, empty_tail, 32'(len), 1'b0);
         end else begin
            repeat ($urandom_range(4, 1)) begin
               send_beat(any_word(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), $urandom);
            end
         end
      end
   endtask

   initial begin
      logic [31:0] seeds [PHASES];
      int unsigned idle_by_mode [4];
      int unsigned stall_by_mode [4];
      int unsigned per_phase;
      int unsigned base;

      seeds         = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0001, $urandom,
                        32'h8000_0000};
      idle_by_mode  = '{0, 87, 0, 32};
      stall_by_mode = '{0, 0, 87, 32};

      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.data_word     = '0;
      req_if.bytes_valid   = '0;
      req_if.first         = 1'b0;
      req_if.last          = 1'b0;
      req_if.total_length  = '0;
      csr_if.valid         = 1'b0;
      csr_if.seed          = '0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      words_sent           = 0;
      sb                   = new();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      run_directed();

      base      = words_sent;
      per_phase = (ITEM_GOAL - base) / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         settle();
         write_seed(seeds[p]);
         run_random(base + per_phase * (p + 1), idle_by_mode[p % 4], stall_by_mode[p % 4]);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      settle();

      if (sb.errors == 0) begin
         $display("tb_murmur64a_hash_top: done, clean");
      end else begin
         $display("tb_murmur64a_hash_top: done, errors");
      end
      $finish;
   end

endmodule
